// ===== design/clru_pkg.sv =====
// Shared types and fixed widths for the LRU page replacement core.
package clru_pkg;

	localparam int CFG_W     = 5;
	localparam int FAULT_W   = 32;
	localparam int IDX_OUT_W = 4;

	localparam logic [CFG_W-1:0]   FRAMES_RESET = 5'd16;
	localparam logic [FAULT_W-1:0] FAULT_MAX    = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} clru_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} clru_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} clru_stat_t;

endpackage

// ===== design/counter_lru_page_replacement_core.sv =====
// Top level of the timestamp LRU page replacement core.
//
//  channel | signals                                  | direction | transaction when
//  --------+------------------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, page_number          | in        | in_valid && !in_stall
//  out     | out_valid, out_stall, fault, frame_index,| out       | out_valid && !out_stall
//          | evicted_valid, evicted_page, fault_total |           |
//  cfg     | cfg_valid, cfg_ready, cfg_data           | in        | cfg_valid && cfg_ready
//
// An access is accepted, then the n frames in use (n being the clamped frame count)
// are read in a serial scan through the single read port of the frame stores, the
// registered read is drained, and the result is decided and committed.
// Reset clears the valid bits and both counters; no clearing pass is needed.
// A stalled result waits in the output register; the next transaction is accepted
// meanwhile, and its commit holds until that result is taken.
module counter_lru_page_replacement_core
	import clru_pkg::*;
#(
	parameter int FRAMES     = 16,
	parameter int PAGE_BITS  = 20,
	parameter int STAMP_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_W-1:0]     cfg_data,
	// access in
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PAGE_BITS-1:0] page_number,
	// result out
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fault,
	output logic [IDX_OUT_W-1:0] frame_index,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [FAULT_W-1:0]   fault_total
);

	clru_cmd_t  cmd;
	clru_stat_t stat;

	// The user must write configuration only while idle; the block does not enforce this and takes every write at once.
	assign cfg_ready = 1'b1;

	// Sequence each access: accept, scan, drain, decide.
	clru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold frames and counters; track hit, first empty and oldest stamp.
	clru_dpath #(
		.FRAMES     (FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid),
		.cfg_data      (cfg_data),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fault         (fault),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

endmodule

// ===== design/clru_ctrl.sv =====
// Controller state machine: accept, frame scan, drain, decide and commit.
module clru_ctrl
	import clru_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  clru_stat_t stat,
	output clru_cmd_t  cmd
);

	clru_state_t state_q;
	clru_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		cmd.start  = (state_q == ST_IDLE) && in_valid;
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_DECIDE) && stat.out_free;
	end

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_SCAN))
		else $error("accepted transaction did not start a scan");

	a_drain_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_DECIDE))
		else $error("drain not followed by decide");

endmodule

// ===== design/clru_dpath.sv =====
// Datapath: frame stores, scan trackers, counters and result register.
module clru_dpath
	import clru_pkg::*;
#(
	parameter int FRAMES     = 16,
	parameter int PAGE_BITS  = 20,
	parameter int STAMP_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clru_cmd_t            cmd,
	output clru_stat_t           stat,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [PAGE_BITS-1:0] page_number,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 fault,
	output logic [IDX_OUT_W-1:0] frame_index,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [FAULT_W-1:0]   fault_total
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);
	localparam int NW = (CW > CFG_W) ? CW : CFG_W;
	localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

	// frame stores
	logic [PAGE_BITS-1:0]  page_mem  [FRAMES];
	logic [STAMP_BITS-1:0] stamp_mem [FRAMES];
	logic [FRAMES-1:0]     valid_q;

	logic [CFG_W-1:0]      frames_cfg_q;
	logic [STAMP_BITS-1:0] access_q;
	logic [FAULT_W-1:0]    faults_q;
	logic [PAGE_BITS-1:0]  page_q;

	// scan
	logic [FW-1:0]         rd_addr_q;
	logic                  rd_en_s1;
	logic [FW-1:0]         rd_idx_s1;
	logic                  rd_valid_s1;
	logic [PAGE_BITS-1:0]  rd_page_s1;
	logic [STAMP_BITS-1:0] rd_stamp_s1;

	// trackers
	logic                  hit_q;
	logic [FW-1:0]         hit_idx_q;
	logic                  empty_q;
	logic [FW-1:0]         empty_idx_q;
	logic                  min_seen_q;
	logic [STAMP_BITS-1:0] min_stamp_q;
	logic [FW-1:0]         min_idx_q;
	logic [PAGE_BITS-1:0]  min_page_q;

	// result register
	logic                  out_valid_q;
	logic                  fault_q;
	logic [IDX_OUT_W-1:0]  frame_index_q;
	logic                  evicted_valid_q;
	logic [PAGE_BITS-1:0]  evicted_page_q;
	logic [FAULT_W-1:0]    fault_total_q;

	logic [NW-1:0]         n_ext;
	logic [NW-1:0]         n_eff;
	logic [FW-1:0]         last_idx;
	logic [FW-1:0]         slot;
	logic                  evict;
	logic [FAULT_W-1:0]    faults_next;

	// clamp the frame count: zero acts as one, above FRAMES acts as FRAMES
	always_comb begin
		n_ext = NW'(frames_cfg_q);
		priority if (n_ext == '0) begin
			n_eff = NW'(1);
		end else if (n_ext > NW'(FRAMES)) begin
			n_eff = NW'(FRAMES);
		end else begin
			n_eff = n_ext;
		end
		last_idx = FW'(n_eff - NW'(1));
	end

	always_comb begin
		evict = !hit_q && !empty_q;
		priority if (hit_q) begin
			slot = hit_idx_q;
		end else if (empty_q) begin
			slot = empty_idx_q;
		end else begin
			slot = min_idx_q;
		end
		faults_next = faults_q;
		if (!hit_q && (faults_q != FAULT_MAX)) begin
			faults_next = faults_q + FAULT_W'(1);
		end
	end

	assign stat.scan_last = cmd.scan && (rd_addr_q == last_idx);
	assign stat.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_cfg_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			frames_cfg_q <= cfg_data;
		end
	end

	// memories: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stamp_mem[slot] <= access_q;
			if (!hit_q) begin
				page_mem[slot] <= page_q;
			end
		end
		rd_page_s1  <= page_mem[rd_addr_q];
		rd_stamp_s1 <= stamp_mem[rd_addr_q];
		rd_valid_s1 <= valid_q[rd_addr_q];
		rd_idx_s1   <= rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			access_q    <= '0;
			faults_q    <= '0;
			rd_addr_q   <= '0;
			rd_en_s1    <= 1'b0;
			hit_q       <= 1'b0;
			empty_q     <= 1'b0;
			min_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.scan;
			if (cmd.start) begin
				rd_addr_q  <= '0;
				hit_q      <= 1'b0;
				empty_q    <= 1'b0;
				min_seen_q <= 1'b0;
			end else if (cmd.scan) begin
				rd_addr_q <= rd_addr_q + FW'(1);
			end
			if (rd_en_s1) begin
				if (!hit_q && rd_valid_s1 && (rd_page_s1 == page_q)) begin
					hit_q <= 1'b1;
				end
				if (!empty_q && !rd_valid_s1) begin
					empty_q <= 1'b1;
				end
				min_seen_q <= 1'b1;
			end
			if (cmd.commit) begin
				valid_q[slot] <= 1'b1;
				faults_q      <= faults_next;
				if (access_q != STAMP_MAX) begin
					access_q <= access_q + STAMP_BITS'(1);
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tracker payload; flags above qualify it
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q <= page_number;
		end
		if (rd_en_s1) begin
			if (!hit_q && rd_valid_s1 && (rd_page_s1 == page_q)) begin
				hit_idx_q <= rd_idx_s1;
			end
			if (!empty_q && !rd_valid_s1) begin
				empty_idx_q <= rd_idx_s1;
			end
			if (!min_seen_q || (rd_stamp_s1 < min_stamp_q)) begin
				min_stamp_q <= rd_stamp_s1;
				min_idx_q   <= rd_idx_s1;
				min_page_q  <= rd_page_s1;
			end
		end
		if (cmd.commit) begin
			fault_q         <= !hit_q;
			frame_index_q   <= IDX_OUT_W'(slot);
			evicted_valid_q <= evict;
			evicted_page_q  <= evict ? min_page_q : '0;
			fault_total_q   <= faults_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign fault         = fault_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_total_q;

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("result overwritten while stalled");

	a_slot_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (slot <= last_idx))
		else $error("chosen frame outside the frames in use");

	a_addr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (rd_addr_q <= last_idx))
		else $error("scan address past the last frame in use");

	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evicted_valid_q |-> fault_q)
		else $error("eviction reported on a hit");

endmodule
